// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the trace renderer RTL.
// Each use expects clk and rst_n to be visible where it is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LTCR_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define LTCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ltcr_pkg.sv =====
// Shared types and constants of the logic trace column renderer.
// No dependencies; the core, queue, front and back use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ltcr_pkg;

  localparam logic [15:0] BLACK = 16'h0000;

  localparam logic [15:0] COLOUR_RESET = 16'hFFFF;
  localparam logic [7:0]  TOP0_RESET   = 8'd0;
  localparam logic [7:0]  TOP1_RESET   = 8'd20;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_COLOUR_CHAN0 = 2'd0,
    REG_COLOUR_CHAN1 = 2'd1,
    REG_TOP_ROW_CHAN0 = 2'd2,
    REG_TOP_ROW_CHAN1 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] colour_chan0;
    logic [15:0] colour_chan1;
    logic [7:0]  top_row_chan0;
    logic [7:0]  top_row_chan1;
  } cfg_t;

  // One job per word that draws something. The head column is the held
  // sample (drawn when has_held); the tail column is the final sample of
  // a capture (drawn when last).
  typedef struct packed {
    logic [7:0] col;
    logic [1:0] prev;
    logic [1:0] cur;
    logic [1:0] nxt;
    logic       has_held;
    logic       last;
  } job_t;

  typedef struct packed {
    logic       holding;
    logic [7:0] column;
  } front_status_t;

endpackage

`default_nettype wire

// ===== rtl/ltcr_ifs.sv =====
// Valid/ready channel interfaces for sample words and pixel words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ltcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] sample_bits;
  logic       capture_end;

  modport source (output valid, output sample_bits, output capture_end, input ready);
  modport sink (input valid, input sample_bits, input capture_end, output ready);
endinterface

interface ltcr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_col;
  logic [7:0]  pixel_row;
  logic [15:0] pixel_colour;
  logic        frame_done;

  modport source (output valid, output pixel_col, output pixel_row, output pixel_colour,
                  output frame_done, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, input pixel_colour,
                input frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/logic_trace_column_renderer_core.sv =====
// Top level of the logic trace column renderer: configuration registers
// and the front, queue and back parts. Depends on ltcr_pkg, ltcr_ifs,
// ltcr_queue, ltcr_front, ltcr_back and assert_macros.svh.
//
//   Channel   Dir  Handshake          Payload
//   in_ch     in   valid/ready        sample_bits[1:0], capture_end
//   out_ch    out  valid/ready        pixel_col, pixel_row, pixel_colour, frame_done
//   cfg_*     in   APB write/read     four registers at byte addresses 0, 4, 8, 12
//
// Each sample word that draws yields CHANNELS*ROWS pixel words per column
// (20 with the defaults), two columns for a final sample that follows a
// held one. The back part emits one pixel word per cycle while the output
// is not stalled, so that walk sets the sustained sample rate.
// Reset is synchronous and active low; it clears all control state and
// returns the registers to their reset values. A two-entry job queue lets
// the front keep taking words while the back is busy or the output stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module logic_trace_column_renderer_core #(
  parameter int ROWS     = 10,
  parameter int CHANNELS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ltcr_in_if.sink          in_ch,
  ltcr_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  ltcr_pkg::cfg_t            cfg_r, cfg_nxt;
  ltcr_pkg::reg_idx_t        reg_idx;
  ltcr_pkg::job_t            push_job, pop_job;
  ltcr_pkg::front_status_t   front_st;
  logic                      q_push, q_pop, q_full, q_not_empty;
  logic [1:0]                q_count;
  logic                      cfg_write;

  // Register file. Writes land in the access phase; pready is tied high so
  // every access completes without wait states.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = ltcr_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (reg_idx)
        ltcr_pkg::REG_COLOUR_CHAN0:  cfg_nxt.colour_chan0  = cfg_pwdata[15:0];
        ltcr_pkg::REG_COLOUR_CHAN1:  cfg_nxt.colour_chan1  = cfg_pwdata[15:0];
        ltcr_pkg::REG_TOP_ROW_CHAN0: cfg_nxt.top_row_chan0 = cfg_pwdata[7:0];
        ltcr_pkg::REG_TOP_ROW_CHAN1: cfg_nxt.top_row_chan1 = cfg_pwdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ltcr_pkg::REG_COLOUR_CHAN0:  cfg_prdata = {16'd0, cfg_r.colour_chan0};
      ltcr_pkg::REG_COLOUR_CHAN1:  cfg_prdata = {16'd0, cfg_r.colour_chan1};
      ltcr_pkg::REG_TOP_ROW_CHAN0: cfg_prdata = {24'd0, cfg_r.top_row_chan0};
      ltcr_pkg::REG_TOP_ROW_CHAN1: cfg_prdata = {24'd0, cfg_r.top_row_chan1};
      default: cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_chan0  <= ltcr_pkg::COLOUR_RESET;
      cfg_r.colour_chan1  <= ltcr_pkg::COLOUR_RESET;
      cfg_r.top_row_chan0 <= ltcr_pkg::TOP0_RESET;
      cfg_r.top_row_chan1 <= ltcr_pkg::TOP1_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front classifies each word and queues at most one job for it.
  ltcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job),
    .status (front_st)
  );

  ltcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // The back draws the job pixel by pixel behind a registered output.
  ltcr_back #(
    .ROWS     (ROWS),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

  // The final pixel of a capture is the bottom row of the last drawn channel.
  localparam logic LastCh = 1'(CHANNELS - 1);
  logic [7:0] last_band_bottom;
  assign last_band_bottom = (LastCh ? cfg_r.top_row_chan1 : cfg_r.top_row_chan0)
                            + 8'(ROWS - 1);

  `LTCR_ASSERT_NEXT(a_end_clears_front, in_ch.valid && in_ch.ready && in_ch.capture_end, !front_st.holding && front_st.column == 8'd0, "capture end did not clear front state")
  `LTCR_ASSERT_NOW(a_stall_means_full, in_ch.ready || q_count == 2'd2, "input stalled with room in the job queue")
  `LTCR_ASSERT_NOW(a_done_on_bottom_row, !(out_ch.valid && out_ch.frame_done) || out_ch.pixel_row == last_band_bottom, "frame_done not on the last band's bottom row")

endmodule

`default_nettype wire

// ===== rtl/ltcr_queue.sv =====
// Two-entry job queue between the front and back of the renderer.
// Depends on ltcr_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module ltcr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ltcr_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output ltcr_pkg::job_t     pop_job,
  output logic               not_empty,
  output logic [1:0]         count
);

  ltcr_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign count     = cnt_r;
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && not_empty;
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ltcr_front.sv =====
// Front part: accepts sample words, tracks neighbours and column count,
// and queues column jobs. Depends on ltcr_pkg and ltcr_ifs.
`timescale 1ns / 1ps
`default_nettype none

module ltcr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ltcr_in_if.sink                   in_ch,
  input  wire logic                 q_full,
  output logic                      q_push,
  output ltcr_pkg::job_t            q_job,
  output ltcr_pkg::front_status_t   status
);

  logic [1:0] held_r, held_nxt;
  logic [1:0] before_r, before_nxt;
  logic       holding_r, holding_nxt;
  logic [7:0] col_r, col_nxt;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    q_job.col      = col_r;
    q_job.prev     = before_r;
    q_job.cur      = held_r;
    q_job.nxt      = in_ch.sample_bits;
    q_job.has_held = holding_r;
    q_job.last     = in_ch.capture_end;
    q_push         = accept && (holding_r || in_ch.capture_end);

    held_nxt    = held_r;
    before_nxt  = before_r;
    holding_nxt = holding_r;
    col_nxt     = col_r;
    if (accept) begin
      priority if (in_ch.capture_end) begin
        held_nxt    = 2'd0;
        before_nxt  = 2'd0;
        holding_nxt = 1'b0;
        col_nxt     = 8'd0;
      end else if (!holding_r) begin
        // First sample of a capture is its own previous neighbour.
        held_nxt    = in_ch.sample_bits;
        before_nxt  = in_ch.sample_bits;
        holding_nxt = 1'b1;
      end else begin
        held_nxt   = in_ch.sample_bits;
        before_nxt = held_r;
        col_nxt    = col_r + 8'd1;
      end
    end
  end

  assign status.holding = holding_r;
  assign status.column  = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 2'd0;
      before_r  <= 2'd0;
      holding_r <= 1'b0;
      col_r     <= 8'd0;
    end else begin
      held_r    <= held_nxt;
      before_r  <= before_nxt;
      holding_r <= holding_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ltcr_back.sv =====
// Back part: walks each queued job column by column, channel by channel
// and row by row, one pixel word per cycle while the output is not
// stalled, into a registered output. Depends on ltcr_pkg and ltcr_ifs.
`timescale 1ns / 1ps
`default_nettype none

module ltcr_back #(
  parameter int ROWS     = 10,
  parameter int CHANNELS = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ltcr_pkg::cfg_t     cfg,
  input  wire logic          q_not_empty,
  input  ltcr_pkg::job_t     q_job,
  output logic               q_pop,
  ltcr_out_if.source         out_ch
);

  localparam int          RowW     = $clog2(ROWS);
  localparam logic [RowW-1:0] ROW_LAST = RowW'(ROWS - 1);
  localparam logic        CH_LAST  = 1'(CHANNELS - 1);

  typedef enum logic {PH_HEAD, PH_TAIL} phase_t;

  ltcr_pkg::job_t job_r;
  logic           job_valid_r, job_valid_nxt;
  phase_t         phase_r, phase_nxt;
  logic           ch_r, ch_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [7:0]  col;
  logic [1:0]  s_bits, p_bits, x_bits;
  logic        s, p, x, edge_col;
  logic [15:0] colour, pix_colour;
  logic [7:0]  top;
  logic        row_last, col_done, job_done, adv, done_pix;

  always_comb begin
    if (phase_r == PH_TAIL) begin
      col    = job_r.col + 8'(job_r.has_held);
      s_bits = job_r.nxt;
      // A final sample with nothing held before it is its own previous.
      p_bits = job_r.has_held ? job_r.cur : job_r.nxt;
      x_bits = job_r.nxt;
    end else begin
      col    = job_r.col;
      s_bits = job_r.cur;
      p_bits = job_r.prev;
      x_bits = job_r.nxt;
    end
    s        = s_bits[ch_r];
    p        = p_bits[ch_r];
    x        = x_bits[ch_r];
    edge_col = s && (!p || !x);
    colour   = ch_r ? cfg.colour_chan1 : cfg.colour_chan0;
    top      = ch_r ? cfg.top_row_chan1 : cfg.top_row_chan0;
    row_last = (row_r == ROW_LAST);

    priority if (edge_col) begin
      pix_colour = colour;
    end else if (s) begin
      pix_colour = (row_r == '0) ? colour : ltcr_pkg::BLACK;
    end else begin
      pix_colour = row_last ? colour : ltcr_pkg::BLACK;
    end

    col_done = row_last && (ch_r == CH_LAST);
    job_done = col_done && (phase_r == PH_TAIL || !job_r.last);
    done_pix = job_done && job_r.last;
    adv      = job_valid_r && (!out_valid_r || out_ch.ready);
    q_pop    = q_not_empty && (!job_valid_r || (adv && job_done));

    job_valid_nxt = job_valid_r;
    phase_nxt     = phase_r;
    ch_nxt        = ch_r;
    row_nxt       = row_r;
    if (adv) begin
      if (row_last) begin
        row_nxt = '0;
        if (ch_r == CH_LAST) begin
          ch_nxt = 1'b0;
          if (job_done) begin
            job_valid_nxt = 1'b0;
          end else begin
            phase_nxt = PH_TAIL;
          end
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      phase_nxt     = q_job.has_held ? PH_HEAD : PH_TAIL;
      ch_nxt        = 1'b0;
      row_nxt       = '0;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      phase_r     <= PH_HEAD;
      ch_r        <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      phase_r     <= phase_nxt;
      ch_r        <= ch_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (adv) begin
      out_ch.pixel_col    <= col;
      out_ch.pixel_row    <= top + 8'(row_r);
      out_ch.pixel_colour <= pix_colour;
      out_ch.frame_done   <= done_pix;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

// ===== test/logic_trace_column_renderer_core_test.sv =====
// Self-checking testbench for logic_trace_column_renderer_core: sample words in, pixel words out.
// It depends on ltcr_pkg, the ltcr_in_if and ltcr_out_if interfaces and the core itself.
// Every pixel word is checked against an in-bench renderer that mirrors the block, or against typed plan rows.
`timescale 1ns / 1ps

module logic_trace_column_renderer_core_test;

  localparam int ROWS     = 10;
  localparam int CHANNELS = 2;
  // Watchdog limit on the length of the run, in cycles.
  localparam int LIMIT    = 400000;
  // Cycles allowed after the last pixel before the block is taken to be idle.
  localparam int SETTLE   = 60;
  localparam int HOLD_AT  = 450;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] colour;
    logic        done;
  } pixel_t;

  // One row of the directed plan. Where typed is set, the first and last pixel
  // of the word's output are given here by hand rather than by the renderer.
  typedef struct packed {
    logic       reconf;
    logic [1:0] lvls;
    logic       fin;
    logic       typed;
    pixel_t     head;
    pixel_t     tail;
  } plan_row_t;

  localparam pixel_t NO_PX = '0;
  localparam int PLAN_LEN = 18;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Single-sample captures under the reset settings: each sample is its
    // own neighbour on both sides, so a high level is never an edge.
    '{1'b0, 2'd3, 1'b1, 1'b1, '{8'd0, 8'd0, 16'hFFFF, 1'b0}, '{8'd0, 8'd29, 16'h0000, 1'b1}},
    '{1'b0, 2'd0, 1'b1, 1'b1, '{8'd0, 8'd0, 16'h0000, 1'b0}, '{8'd0, 8'd29, 16'hFFFF, 1'b1}},
    '{1'b0, 2'd1, 1'b1, 1'b1, '{8'd0, 8'd0, 16'hFFFF, 1'b0}, '{8'd0, 8'd29, 16'hFFFF, 1'b1}},
    '{1'b0, 2'd2, 1'b1, 1'b1, '{8'd0, 8'd0, 16'h0000, 1'b0}, '{8'd0, 8'd29, 16'h0000, 1'b1}},
    // A longer capture with rising and falling edges, steady highs and lows.
    '{1'b0, 2'd0, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd1, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd3, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd2, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd0, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd3, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd3, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd3, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd1, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd2, 1'b1, 1'b0, NO_PX, NO_PX},
    // Extreme settings: black channel zero from row 255, channel one from row
    // 250, so both bands wrap past the bottom of the screen.
    '{1'b1, 2'd3, 1'b1, 1'b1, '{8'd0, 8'd255, 16'h0000, 1'b0}, '{8'd0, 8'd3, 16'h0000, 1'b1}},
    '{1'b0, 2'd1, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd2, 1'b0, 1'b0, NO_PX, NO_PX},
    '{1'b0, 2'd0, 1'b1, 1'b0, NO_PX, NO_PX}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ltcr_in_if  sample_ch ();
  ltcr_out_if pixel_ch ();

  logic_trace_column_renderer_core #(
    .ROWS(ROWS),
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(sample_ch),
    .out_ch(pixel_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow of the configuration registers and of the renderer's own state.
  ltcr_pkg::cfg_t shadow_cfg;
  logic [1:0] held_lvls;
  logic [1:0] prior_lvls;
  logic       holding;
  logic [7:0] next_col;

  // Pixels still owed by the block, oldest first.
  pixel_t pixel_expect [$];
  int     fails;
  int     pix_seen;
  int     rnd_items;
  int     cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that has not finished by the limit has hung somewhere.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("logic_trace_column_renderer_core_test: done, errors");
    $finish;
  end

  // Draws one pixel column for every channel and queues the pixels in the
  // order the block emits them: channel zero top to bottom, then channel one.
  task automatic draw_column(input logic [7:0] col, input logic [1:0] cur,
                             input logic [1:0] prev, input logic [1:0] nxt,
                             input logic last);
    pixel_t      px;
    logic [15:0] hue;
    logic [7:0]  top;
    logic        lvl;
    logic        flank;
    int          ch;
    int          r;
    for (ch = 0; ch < CHANNELS; ch++) begin
      lvl   = cur[ch];
      // A high sample next to a low one on either side is drawn as an edge.
      flank = lvl && (!prev[ch] || !nxt[ch]);
      hue   = (ch == 1) ? shadow_cfg.colour_chan1 : shadow_cfg.colour_chan0;
      top   = (ch == 1) ? shadow_cfg.top_row_chan1 : shadow_cfg.top_row_chan0;
      for (r = 0; r < ROWS; r++) begin
        px.col = col;
        px.row = top + 8'(r);
        if (flank) begin
          px.colour = hue;
        end else if (lvl) begin
          px.colour = (r == 0) ? hue : ltcr_pkg::BLACK;
        end else begin
          px.colour = (r == ROWS - 1) ? hue : ltcr_pkg::BLACK;
        end
        px.done = last && (ch == CHANNELS - 1) && (r == ROWS - 1);
        pixel_expect.push_back(px);
      end
    end
  endtask

  // Advances the renderer by one accepted sample word. The held sample is drawn
  // once its successor is known; a final sample is drawn at once as its own
  // successor, after which the capture state returns to its reset values.
  task automatic render_sample(input logic [1:0] lvls, input logic fin);
    if (!holding) begin
      prior_lvls = lvls;
      held_lvls  = lvls;
      holding    = 1'b1;
    end else begin
      draw_column(next_col, held_lvls, prior_lvls, lvls, 1'b0);
      prior_lvls = held_lvls;
      held_lvls  = lvls;
      next_col   = next_col + 8'd1;
    end
    if (fin) begin
      draw_column(next_col, held_lvls, prior_lvls, held_lvls, 1'b1);
      held_lvls  = '0;
      prior_lvls = '0;
      holding    = 1'b0;
      next_col   = '0;
    end
  endtask

  // Offers one sample word, after a random gap unless calm is set, and waits
  // for the block to take it. first_at is where its pixels begin in the queue.
  task automatic send_sample(input logic [1:0] lvls, input logic fin, input bit calm,
                             output int first_at);
    while (!calm && $urandom_range(99) < 29) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample_bits <= lvls;
    sample_ch.capture_end <= fin;
    do begin
      @(posedge clk);
    end while (!sample_ch.ready);
    first_at = pixel_expect.size();
    render_sample(lvls, fin);
  endtask

  task automatic reg_write(input ltcr_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      ltcr_pkg::REG_COLOUR_CHAN0:  shadow_cfg.colour_chan0  = val[15:0];
      ltcr_pkg::REG_COLOUR_CHAN1:  shadow_cfg.colour_chan1  = val[15:0];
      ltcr_pkg::REG_TOP_ROW_CHAN0: shadow_cfg.top_row_chan0 = val[7:0];
      ltcr_pkg::REG_TOP_ROW_CHAN1: shadow_cfg.top_row_chan1 = val[7:0];
      default: ;
    endcase
  endtask

  // Reads a register back and compares the bits that the register holds.
  task automatic reg_check(input ltcr_pkg::reg_idx_t idx);
    logic [31:0] got;
    logic [15:0] want;
    logic [15:0] mask;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      ltcr_pkg::REG_COLOUR_CHAN0: begin
        want = shadow_cfg.colour_chan0;
        mask = 16'hFFFF;
      end
      ltcr_pkg::REG_COLOUR_CHAN1: begin
        want = shadow_cfg.colour_chan1;
        mask = 16'hFFFF;
      end
      ltcr_pkg::REG_TOP_ROW_CHAN0: begin
        want = {8'd0, shadow_cfg.top_row_chan0};
        mask = 16'h00FF;
      end
      default: begin
        want = {8'd0, shadow_cfg.top_row_chan1};
        mask = 16'h00FF;
      end
    endcase
    if ((got[15:0] & mask) != want) begin
      $error("register %s: expected %h, got %h", idx.name(), want, got[15:0] & mask);
      fails++;
    end
  endtask

  // Lets the block run dry, then writes all four registers (upper data bits
  // random, since only the low bits are kept) and reads each one back.
  task automatic apply_config(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [7:0] t0, input logic [7:0] t1);
    sample_ch.valid <= 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    reg_write(ltcr_pkg::REG_COLOUR_CHAN0, {16'($urandom), c0});
    reg_write(ltcr_pkg::REG_COLOUR_CHAN1, {16'($urandom), c1});
    reg_write(ltcr_pkg::REG_TOP_ROW_CHAN0, {24'($urandom), t0});
    reg_write(ltcr_pkg::REG_TOP_ROW_CHAN1, {24'($urandom), t1});
    reg_check(ltcr_pkg::REG_COLOUR_CHAN0);
    reg_check(ltcr_pkg::REG_COLOUR_CHAN1);
    reg_check(ltcr_pkg::REG_TOP_ROW_CHAN0);
    reg_check(ltcr_pkg::REG_TOP_ROW_CHAN1);
  endtask

  function automatic logic [15:0] pick_colour();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_top();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Pixel receiver. Ready drops with a chance of roughly 29 in a hundred, except
  // for a calm stretch of the run; once, after HOLD_AT pixels, it holds off for
  // a stretch set by HOLD_LEN so that the job queue fills and the input stalls.
  initial begin
    pixel_t got;
    pixel_t want;
    int     hold_left;
    bit     held_once;
    bit     calm;
    hold_left = 0;
    held_once = 1'b0;
    pixel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
        got = '{pixel_ch.pixel_col, pixel_ch.pixel_row, pixel_ch.pixel_colour,
                pixel_ch.frame_done};
        pix_seen++;
        if (pixel_expect.size() == 0) begin
          $error("pixel word with nothing expected: col %0d row %0d colour %h done %b",
                 got.col, got.row, got.colour, got.done);
          fails++;
        end else begin
          want = pixel_expect.pop_front();
          if (got.col != want.col) begin
            $error("pixel_col: expected %0d, got %0d", want.col, got.col);
            fails++;
          end
          if (got.row != want.row) begin
            $error("pixel_row: expected %0d, got %0d", want.row, got.row);
            fails++;
          end
          if (got.colour != want.colour) begin
            $error("pixel_colour: expected %h, got %h", want.colour, got.colour);
            fails++;
          end
          if (got.done != want.done) begin
            $error("frame_done: expected %b, got %b", want.done, got.done);
            fails++;
          end
        end
      end
      calm = (pix_seen >= 1200) && (pix_seen < 1700);
      if (hold_left > 0) begin
        hold_left--;
        pixel_ch.ready <= 1'b0;
      end else if (!held_once && pix_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN - 1;
        pixel_ch.ready <= 1'b0;
      end else begin
        pixel_ch.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // Stimulus: the directed plan, then random captures under a series of
  // settings, then a drain before the verdict.
  initial begin
    int        first_at;
    int        k;
    int        phase;
    int        sent;
    int        len;
    plan_row_t step;
    fails     = 0;
    pix_seen  = 0;
    rnd_items = 0;
    shadow_cfg = '{ltcr_pkg::COLOUR_RESET, ltcr_pkg::COLOUR_RESET,
                   ltcr_pkg::TOP0_RESET, ltcr_pkg::TOP1_RESET};
    held_lvls  = '0;
    prior_lvls = '0;
    holding    = 1'b0;
    next_col   = '0;
    rst_n                 <= 1'b0;
    sample_ch.valid       <= 1'b0;
    sample_ch.sample_bits <= '0;
    sample_ch.capture_end <= 1'b0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan. Typed rows overwrite the first and last pixel that the
    // renderer queued with the values written out in the table.
    for (k = 0; k < PLAN_LEN; k++) begin
      step = PLAN[k];
      if (step.reconf) begin
        apply_config(16'h0000, 16'hFFFF, 8'd255, 8'd250);
      end
      send_sample(step.lvls, step.fin, 1'b0, first_at);
      if (step.typed) begin
        pixel_expect[first_at] = step.head;
        pixel_expect[pixel_expect.size() - 1] = step.tail;
      end
    end

    // Random captures. Each setting carries several captures of random length.
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        apply_config(16'hFFFF, 16'h0000, 8'd0, 8'd255);
      end else begin
        apply_config(pick_colour(), pick_colour(), pick_top(), pick_top());
      end
      sent = 0;
      while (sent < 16) begin
        len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
        for (k = 0; k < len; k++) begin
          send_sample(2'($urandom), k == len - 1, rnd_items >= 40 && rnd_items < 70,
                      first_at);
          rnd_items++;
          sent++;
        end
      end
    end
    sample_ch.valid <= 1'b0;

    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pixel_expect.size() == 0) begin
      $display("logic_trace_column_renderer_core_test: done, clean");
    end else begin
      $display("logic_trace_column_renderer_core_test: done, errors");
    end
    $finish;
  end

endmodule
